[rtl/lcks_pkg.sv]
// Shared types and constants for the LIFO cache with key search.
`timescale 1ns / 1ps

package lcks_pkg;

	localparam int FIELD_W       = 64;
	localparam int OP_W          = 2;
	localparam int STATUS_W      = 2;
	localparam int OCC_W         = 7;

	localparam int DEPTH_DEF     = 64;
	localparam int KEY_BITS_DEF  = 64;
	localparam int DATA_BITS_DEF = 64;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

endpackage

[rtl/lcks_if.sv]
// Request and response channel interfaces (valid/ready with payload).
`timescale 1ns / 1ps

interface lcks_req_if;
	logic                        valid;
	logic                        ready;
	logic [lcks_pkg::OP_W-1:0]    operation;
	logic [lcks_pkg::FIELD_W-1:0] key;
	logic [lcks_pkg::FIELD_W-1:0] entry_data;

	modport source (output valid, operation, key, entry_data, input ready);
	modport sink   (input valid, operation, key, entry_data, output ready);
endinterface

interface lcks_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [lcks_pkg::STATUS_W-1:0]  status;
	logic [lcks_pkg::FIELD_W-1:0]   out_key;
	logic [lcks_pkg::FIELD_W-1:0]   out_data;
	logic [lcks_pkg::OCC_W-1:0]     occupancy;

	modport source (output valid, status, out_key, out_data, occupancy, input ready);
	modport sink   (input valid, status, out_key, out_data, occupancy, output ready);
endinterface

[rtl/lcks_front.sv]
// Front end: registers a request, decodes the operation and trims key and payload.
`timescale 1ns / 1ps

module lcks_front #(
	parameter int KEY_BITS  = lcks_pkg::KEY_BITS_DEF,
	parameter int DATA_BITS = lcks_pkg::DATA_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lcks_req_if.sink             req,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output lcks_pkg::op_t        cmd_op,
	output logic [KEY_BITS-1:0]  cmd_key,
	output logic [DATA_BITS-1:0] cmd_data
);
	import lcks_pkg::*;

	logic                 vld_s1;
	op_t                  op_s1;
	logic [KEY_BITS-1:0]  key_s1;
	logic [DATA_BITS-1:0] data_s1;

	assign req.ready = !vld_s1 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			op_s1   <= OP_PUSH;
			key_s1  <= '0;
			data_s1 <= '0;
		end else begin
			if (req.valid && req.ready) begin
				vld_s1  <= 1'b1;
				op_s1   <= op_t'(req.operation);
				key_s1  <= req.key[KEY_BITS-1:0];
				data_s1 <= req.entry_data[DATA_BITS-1:0];
			end else if (cmd_ready) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	assign cmd_valid = vld_s1;
	assign cmd_op    = op_s1;
	assign cmd_key   = key_s1;
	assign cmd_data  = data_s1;

endmodule

[rtl/lcks_queue.sv]
// Two-entry command queue between the front end and the execution unit.
`timescale 1ns / 1ps

module lcks_queue #(
	parameter int W = 130
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);
	localparam int NENT = 2;

	logic [W-1:0] slot_q [NENT];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	assign in_ready  = (cnt_q != 2'(NENT));
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= in_data;
	end

	// occupancy bounded; an empty queue shows no entry
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(NENT)) else $error("queue count beyond depth");

endmodule

[rtl/lcks_back.sv]
// Execution unit: entry memory, stack pointer, newest-first key scan, result register.
`timescale 1ns / 1ps

module lcks_back #(
	parameter int DEPTH     = lcks_pkg::DEPTH_DEF,
	parameter int KEY_BITS  = lcks_pkg::KEY_BITS_DEF,
	parameter int DATA_BITS = lcks_pkg::DATA_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  lcks_pkg::op_t        cmd_op,
	input  logic [KEY_BITS-1:0]  cmd_key,
	input  logic [DATA_BITS-1:0] cmd_data,
	lcks_rsp_if.source           rsp
);
	import lcks_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        cnt_q;
	logic [AW-1:0]        idx_q;
	logic [KEY_BITS-1:0]  key_q;

	logic [KEY_BITS-1:0]  mem_key  [DEPTH];
	logic [DATA_BITS-1:0] mem_data [DEPTH];
	logic [KEY_BITS-1:0]  rkey_q;
	logic [DATA_BITS-1:0] rdata_q;

	logic                 out_vld_q;
	status_t              out_status_q;
	logic [FIELD_W-1:0]   out_key_q;
	logic [FIELD_W-1:0]   out_data_q;
	logic [OCC_W-1:0]     out_occ_q;

	logic                 start;
	logic                 full;
	logic                 empty;
	logic                 hit;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;

	assign full      = (cnt_q == CW'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign hit       = (rkey_q == key_q);
	assign start     = cmd_valid && (state_q == S_IDLE) && (!out_vld_q || rsp.ready);
	assign cmd_ready = start;

	always_comb begin
		wr_en   = start && (cmd_op == OP_PUSH) && !full;
		wr_addr = AW'(cnt_q);
		rd_en   = 1'b0;
		rd_addr = AW'(cnt_q - CW'(1));
		if (start && !empty && (cmd_op == OP_POP || cmd_op == OP_LOOKUP)) begin
			rd_en = 1'b1;
		end else if (state_q == S_SCAN && !hit && idx_q != '0) begin
			rd_en   = 1'b1;
			rd_addr = AW'(idx_q - AW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_key[wr_addr]  <= cmd_key;
			mem_data[wr_addr] <= cmd_data;
		end
		if (rd_en) begin
			rkey_q  <= mem_key[rd_addr];
			rdata_q <= mem_data[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			idx_q        <= '0;
			key_q        <= '0;
			out_vld_q    <= 1'b0;
			out_status_q <= ST_OK;
			out_key_q    <= '0;
			out_data_q   <= '0;
			out_occ_q    <= '0;
		end else begin
			if (out_vld_q && rsp.ready) out_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q      <= cmd_key;
						out_key_q  <= '0;
						out_data_q <= '0;
						unique case (cmd_op)
							OP_PUSH: begin
								out_vld_q <= 1'b1;
								if (full) begin
									out_status_q <= ST_FULL;
									out_occ_q    <= OCC_W'(cnt_q);
								end else begin
									cnt_q        <= CW'(cnt_q + CW'(1));
									out_status_q <= ST_OK;
									out_occ_q    <= OCC_W'(cnt_q + CW'(1));
								end
							end
							OP_POP: begin
								if (empty) begin
									out_vld_q    <= 1'b1;
									out_status_q <= ST_EMPTY;
									out_occ_q    <= OCC_W'(cnt_q);
								end else begin
									cnt_q   <= CW'(cnt_q - CW'(1));
									state_q <= S_POP;
								end
							end
							OP_LOOKUP: begin
								if (empty) begin
									out_vld_q    <= 1'b1;
									out_status_q <= ST_MISS;
									out_occ_q    <= OCC_W'(cnt_q);
								end else begin
									idx_q   <= AW'(cnt_q - CW'(1));
									state_q <= S_SCAN;
								end
							end
							OP_CLEAR: begin
								cnt_q        <= '0;
								out_vld_q    <= 1'b1;
								out_status_q <= ST_OK;
								out_occ_q    <= '0;
							end
						endcase
					end
				end
				S_POP: begin
					out_vld_q    <= 1'b1;
					out_status_q <= ST_OK;
					out_key_q    <= FIELD_W'(rkey_q);
					out_data_q   <= FIELD_W'(rdata_q);
					out_occ_q    <= OCC_W'(cnt_q);
					state_q      <= S_IDLE;
				end
				S_SCAN: begin
					if (hit) begin
						out_vld_q    <= 1'b1;
						out_status_q <= ST_OK;
						out_key_q    <= FIELD_W'(rkey_q);
						out_data_q   <= FIELD_W'(rdata_q);
						out_occ_q    <= OCC_W'(cnt_q);
						state_q      <= S_IDLE;
					end else if (idx_q == '0) begin
						out_vld_q    <= 1'b1;
						out_status_q <= ST_MISS;
						out_occ_q    <= OCC_W'(cnt_q);
						state_q      <= S_IDLE;
					end else begin
						idx_q <= AW'(idx_q - AW'(1));
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.status    = out_status_q;
	assign rsp.out_key   = out_key_q;
	assign rsp.out_data  = out_data_q;
	assign rsp.occupancy = out_occ_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("entry count beyond depth");

	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (CW'(idx_q) < cnt_q)) else $error("scan index above top");

	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(start && cmd_op == OP_PUSH && !full) |=> (cnt_q == CW'($past(cnt_q) + CW'(1))))
		else $error("push did not advance count");

	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd_ready) else $error("command taken while busy");

endmodule

[rtl/lifo_cache_with_key_search.sv]
// Top level: LIFO entry cache with newest-first key lookup.
`timescale 1ns / 1ps
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+--------------------------------------------
//  req     | in  | valid/ready      | operation, key, entry_data
//  rsp     | out | valid/ready      | status, out_key, out_data, occupancy
//
//  Path: a request passes the front register and the queue; push, clear and an empty
//  pop or lookup reply from S_IDLE; a pop goes via S_POP, a lookup scans in S_SCAN.
//  Reset: arst_n clears control and the entry count; the entry memory is not
//  cleared and needs no sweep, so requests are taken right after reset.
//  Stalls: a held response only blocks the execution unit from starting its
//  next command; the front end and queue keep taking requests until full.

module lifo_cache_with_key_search #(
	parameter int DEPTH     = lcks_pkg::DEPTH_DEF,
	parameter int KEY_BITS  = lcks_pkg::KEY_BITS_DEF,
	parameter int DATA_BITS = lcks_pkg::DATA_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lcks_req_if.sink   req,
	lcks_rsp_if.source rsp
);
	import lcks_pkg::*;

	// queue word: operation code, trimmed key, trimmed payload
	localparam int QW = OP_W + KEY_BITS + DATA_BITS;

	logic                 f_valid;
	logic                 f_ready;
	op_t                  f_op;
	logic [KEY_BITS-1:0]  f_key;
	logic [DATA_BITS-1:0] f_data;

	logic [QW-1:0]        q_in;
	logic [QW-1:0]        q_out;
	logic                 q_valid;
	logic                 q_ready;

	op_t                  b_op;
	logic [KEY_BITS-1:0]  b_key;
	logic [DATA_BITS-1:0] b_data;

	lcks_front #(
		.KEY_BITS  (KEY_BITS),
		.DATA_BITS (DATA_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd_op    (f_op),
		.cmd_key   (f_key),
		.cmd_data  (f_data)
	);

	assign q_in = {f_op, f_key, f_data};

	lcks_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (q_in),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_out)
	);

	// unpack the queue head for the execution unit
	assign b_op   = op_t'(q_out[QW-1 -: OP_W]);
	assign b_key  = q_out[DATA_BITS +: KEY_BITS];
	assign b_data = q_out[DATA_BITS-1:0];

	lcks_back #(
		.DEPTH     (DEPTH),
		.KEY_BITS  (KEY_BITS),
		.DATA_BITS (DATA_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd_op    (b_op),
		.cmd_key   (b_key),
		.cmd_data  (b_data),
		.rsp       (rsp)
	);

endmodule
